// ===== sv/bpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, payload types and control types of the buddy allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int MAX_PAGES  = 4096;
   localparam int NUM_ORDERS = 16;

   localparam int PAGE_W = $clog2(MAX_PAGES);
   localparam int LINK_W = PAGE_W + 1;
   localparam int ORD_W  = $clog2(NUM_ORDERS);
   localparam int BASE_W = 20;
   localparam int CNT_W  = 13;
   localparam int ABS_W  = BASE_W + 1;
   localparam int BIG_W  = ((PAGE_W > NUM_ORDERS) ? PAGE_W : NUM_ORDERS) + 1;

   localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_PAGES);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] OP_INIT  = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   localparam logic [1:0] RS_OK    = 2'd0;
   localparam logic [1:0] RS_NOMEM = 2'd1;
   localparam logic [1:0] RS_RANGE = 2'd2;
   localparam logic [1:0] RS_FREED = 2'd3;

   localparam logic [1:0] REG_BASE  = 2'd0;
   localparam logic [1:0] REG_COUNT = 2'd1;
   localparam logic [1:0] REG_USED  = 2'd2;

   localparam logic [BASE_W-1:0] BASE_RST  = '0;
   localparam logic [CNT_W-1:0]  COUNT_RST = CNT_W'(4096);
   localparam logic              USED_RST  = 1'b0;

   typedef struct packed {
      logic [1:0]        op;
      logic [ORD_W-1:0]  order;
      logic [PAGE_W-1:0] page_index;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [PAGE_W-1:0] block_page;
      logic [ORD_W-1:0]  block_order;
   } rsp_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_LATCH,
      DP_INIT_START,
      DP_INIT_PAGE,
      DP_INIT_LINK,
      DP_A_SEARCH,
      DP_SPLIT_RD,
      DP_SPLIT_UNL,
      DP_SPLIT_PH1,
      DP_SPLIT_PH2,
      DP_SPLIT_PH3,
      DP_FIN_RD,
      DP_FIN_UNL,
      DP_F_RD,
      DP_F_CHK,
      DP_M_CALC,
      DP_M_CHK,
      DP_F_PH1,
      DP_F_PH2,
      DP_MARK,
      DP_LOAD_OUT
   } dp_op_type;

   typedef enum logic [4:0] {
      CS_IDLE,
      CS_INIT_START,
      CS_INIT_PAGE,
      CS_INIT_LINK,
      CS_A_SEARCH,
      CS_SPLIT_RD,
      CS_SPLIT_UNL,
      CS_SPLIT_PH1,
      CS_SPLIT_PH2,
      CS_SPLIT_PH3,
      CS_FIN_RD,
      CS_FIN_UNL,
      CS_F_RD,
      CS_F_CHK,
      CS_M_CALC,
      CS_M_CHK,
      CS_F_PH1,
      CS_F_PH2,
      CS_MARK,
      CS_DONE
   } ctl_state_type;

   typedef struct packed {
      logic found;
      logic more;
      logic init_end;
      logic need_link;
      logic range_err;
      logic free_err;
      logic merge_stop;
      logic buddy_ok;
      logic mark_done;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== sv/bpa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer of the allocator: walks each request through its micro-steps.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_op,
   input  dp_stat_type dp_stat,
   output dp_op_type   dp_op,
   output logic        req_stall
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dp_op     = DP_NOP;
      req_stall = (state_ff != CS_IDLE);
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               dp_op = DP_LATCH;
               case (req_op)
                  OP_INIT:  state_in = CS_INIT_START;
                  OP_ALLOC: state_in = CS_A_SEARCH;
                  OP_FREE:  state_in = CS_F_RD;
                  default:  state_in = CS_DONE;
               endcase
            end
         end
         CS_INIT_START: begin
            dp_op    = DP_INIT_START;
            state_in = CS_INIT_PAGE;
         end
         CS_INIT_PAGE: begin
            dp_op = DP_INIT_PAGE;
            if (dp_stat.init_end) begin
               state_in = CS_DONE;
            end else if (dp_stat.need_link) begin
               state_in = CS_INIT_LINK;
            end
         end
         CS_INIT_LINK: begin
            dp_op    = DP_INIT_LINK;
            state_in = CS_INIT_PAGE;
         end
         CS_A_SEARCH: begin
            dp_op = DP_A_SEARCH;
            if (!dp_stat.found) begin
               state_in = CS_DONE;
            end else if (dp_stat.more) begin
               state_in = CS_SPLIT_RD;
            end else begin
               state_in = CS_FIN_RD;
            end
         end
         CS_SPLIT_RD: begin
            dp_op    = DP_SPLIT_RD;
            state_in = CS_SPLIT_UNL;
         end
         CS_SPLIT_UNL: begin
            dp_op    = DP_SPLIT_UNL;
            state_in = CS_SPLIT_PH1;
         end
         CS_SPLIT_PH1: begin
            dp_op    = DP_SPLIT_PH1;
            state_in = CS_SPLIT_PH2;
         end
         CS_SPLIT_PH2: begin
            dp_op    = DP_SPLIT_PH2;
            state_in = CS_SPLIT_PH3;
         end
         CS_SPLIT_PH3: begin
            dp_op    = DP_SPLIT_PH3;
            state_in = dp_stat.more ? CS_SPLIT_RD : CS_FIN_RD;
         end
         CS_FIN_RD: begin
            dp_op    = DP_FIN_RD;
            state_in = CS_FIN_UNL;
         end
         CS_FIN_UNL: begin
            dp_op    = DP_FIN_UNL;
            state_in = CS_MARK;
         end
         CS_F_RD: begin
            dp_op    = DP_F_RD;
            state_in = dp_stat.range_err ? CS_DONE : CS_F_CHK;
         end
         CS_F_CHK: begin
            dp_op    = DP_F_CHK;
            state_in = dp_stat.free_err ? CS_DONE : CS_M_CALC;
         end
         CS_M_CALC: begin
            dp_op    = DP_M_CALC;
            state_in = dp_stat.merge_stop ? CS_F_PH1 : CS_M_CHK;
         end
         CS_M_CHK: begin
            dp_op    = DP_M_CHK;
            state_in = dp_stat.buddy_ok ? CS_M_CALC : CS_F_PH1;
         end
         CS_F_PH1: begin
            dp_op    = DP_F_PH1;
            state_in = CS_F_PH2;
         end
         CS_F_PH2: begin
            dp_op    = DP_F_PH2;
            state_in = CS_MARK;
         end
         CS_MARK: begin
            dp_op = DP_MARK;
            if (dp_stat.mark_done) begin
               state_in = CS_DONE;
            end
         end
         CS_DONE: begin
            // hold the result until the output register frees up
            if (dp_stat.out_free) begin
               dp_op    = DP_LOAD_OUT;
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/bpa_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_dpath
// Page tables, free lists and scratch registers of the buddy allocator.
// ----------------------------------------------------------------------------
module bpa_dpath import bpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_op_type         dp_op,
   input  req_type           req_data,
   input  logic              rsp_stall,
   input  logic [BASE_W-1:0] seg_base,
   input  logic [CNT_W-1:0]  seg_count,
   input  logic              seg_used,
   output dp_stat_type       dp_stat,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   function automatic logic [ORD_W-1:0] tz_cap(input logic [ABS_W-1:0] v);
      logic [ORD_W-1:0] r;
      r = ORD_W'(NUM_ORDERS - 1);
      for (int k = NUM_ORDERS - 2; k >= 0; k--) begin
         if (v[k]) r = ORD_W'(k);
      end
      return r;
   endfunction

   function automatic logic [ORD_W-1:0] hb_cap(input logic [ABS_W-1:0] v);
      logic [ORD_W-1:0] r;
      r = '0;
      for (int k = 0; k < ABS_W; k++) begin
         if (v[k]) r = (k > NUM_ORDERS - 1) ? ORD_W'(NUM_ORDERS - 1) : ORD_W'(k);
      end
      return r;
   endfunction

   // page tables
   logic [ORD_W-1:0]  ord_mem [MAX_PAGES];
   logic              mgd_mem [MAX_PAGES];
   logic              alc_mem [MAX_PAGES];
   logic [LINK_W-1:0] nxt_mem [MAX_PAGES];
   logic [LINK_W-1:0] prv_mem [MAX_PAGES];

   logic [ORD_W-1:0]  ord_rd_ff;
   logic              mgd_rd_ff;
   logic              alc_rd_ff;
   logic [LINK_W-1:0] nxt_rd_ff;
   logic [LINK_W-1:0] prv_rd_ff;

   logic [PAGE_W-1:0] rd_addr;
   logic              ord_we, mgd_we, alc_we, nxt_we, prv_we;
   logic [PAGE_W-1:0] ord_wa, mgd_wa, alc_wa, nxt_wa, prv_wa;
   logic [ORD_W-1:0]  ord_wd;
   logic              mgd_wd, alc_wd;
   logic [LINK_W-1:0] nxt_wd, prv_wd;

   // per-order list ends
   logic [LINK_W-1:0] head_ff [NUM_ORDERS];
   logic [LINK_W-1:0] tail_ff [NUM_ORDERS];
   logic              head_we, tail_we, clr_lists;
   logic [LINK_W-1:0] head_in, tail_in;
   logic [ORD_W-1:0]  lidx;
   logic [LINK_W-1:0] cur_head, cur_tail;

   // scratch registers
   logic [ORD_W-1:0]  want_ff, want_in, fl_ff, fl_in, o_ff, o_in;
   logic [PAGE_W-1:0] idx_ff, idx_in, p_ff, p_in, b_ff, b_in;
   logic              bok_ff, bok_in;
   logic [LINK_W-1:0] h_ff, h_in, t_ff, t_in, i_ff, i_in;
   logic [BIG_W-1:0]  nhead_ff, nhead_in;
   logic [LINK_W-1:0] mark_addr_ff, mark_addr_in, mark_end_ff, mark_end_in;
   logic              mark_val_ff, mark_val_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // derived values
   logic [CNT_W-1:0]  n_pages;
   logic [BIG_W-1:0]  n_big;
   logic [ABS_W-1:0]  pa, end_pa;
   logic [ORD_W-1:0]  o_tz, init_ord;
   logic [ABS_W:0]    init_span;
   logic              is_head, init_end;
   logic              srch_found;
   logic [ORD_W-1:0]  srch_idx;
   logic [ORD_W-1:0]  s_ord;
   logic [BIG_W-1:0]  sp_sum;
   logic [BIG_W-1:0]  s_big, pe, bsum;
   logic              aligned, merge_stop, buddy_ok;
   logic [BIG_W-1:0]  fr_sum;
   logic [ORD_W-1:0]  mk_ord;
   logic [BIG_W-1:0]  mk_sum;
   logic [LINK_W-1:0] mk_end;
   logic [PAGE_W-1:0] new_p;
   logic              mark_done;

   assign n_pages  = (seg_count > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : seg_count;
   assign n_big    = BIG_W'(n_pages);

   // init: maximal block at this page by absolute alignment, clipped at the end
   assign pa        = ABS_W'(seg_base) + ABS_W'(i_ff);
   assign end_pa    = ABS_W'(seg_base) + ABS_W'(n_pages);
   assign o_tz      = tz_cap(pa);
   assign init_span = (ABS_W + 1)'(pa) + ((ABS_W + 1)'(1) << o_tz);
   assign init_ord  = (init_span > (ABS_W + 1)'(end_pa)) ? hb_cap(end_pa ^ pa) : o_tz;
   assign is_head   = (BIG_W'(i_ff) == nhead_ff) && !seg_used;
   assign init_end  = BIG_W'(i_ff) >= n_big;

   always_comb begin
      srch_found = 1'b0;
      srch_idx   = '0;
      for (int k = NUM_ORDERS - 1; k >= 0; k--) begin
         if (head_ff[k] != NIL && ORD_W'(k) >= want_ff) begin
            srch_found = 1'b1;
            srch_idx   = ORD_W'(k);
         end
      end
   end

   assign s_ord  = fl_ff - 1'b1;
   assign sp_sum = BIG_W'(p_ff) + (BIG_W'(1) << s_ord);

   // buddy of the current block by relative index
   assign s_big      = BIG_W'(1) << o_ff;
   assign pe         = BIG_W'(p_ff);
   assign aligned    = (pe & ((s_big << 1) - BIG_W'(1))) == '0;
   assign bsum       = aligned ? (pe + s_big) : (pe - s_big);
   assign merge_stop = (o_ff == ORD_W'(NUM_ORDERS - 1)) || (!aligned && (pe < s_big))
                       || (bsum >= n_big);
   assign buddy_ok   = (ord_rd_ff == o_ff) && mgd_rd_ff;
   assign new_p      = (b_ff < p_ff) ? b_ff : p_ff;

   assign fr_sum = BIG_W'(idx_ff) + (BIG_W'(1) << ord_rd_ff);

   assign mk_ord    = (dp_op == DP_FIN_UNL) ? fl_ff : o_ff;
   assign mk_sum    = BIG_W'(p_ff) + (BIG_W'(1) << mk_ord);
   assign mk_end    = (mk_sum > BIG_W'(MAX_PAGES)) ? NIL : LINK_W'(mk_sum);
   assign mark_done = mark_addr_ff >= mark_end_ff;

   always_comb begin
      case (dp_op) inside
         DP_INIT_PAGE:                              lidx = init_ord;
         DP_SPLIT_PH1, DP_SPLIT_PH2:                lidx = s_ord;
         DP_M_CHK, DP_F_PH1:                        lidx = o_ff;
         default:                                   lidx = fl_ff;
      endcase
   end

   assign cur_head = head_ff[lidx];
   assign cur_tail = tail_ff[lidx];

   always_comb begin
      rd_addr   = '0;
      ord_we    = 1'b0;  ord_wa = '0;  ord_wd = '0;
      mgd_we    = 1'b0;  mgd_wa = '0;  mgd_wd = 1'b0;
      alc_we    = 1'b0;  alc_wa = '0;  alc_wd = 1'b0;
      nxt_we    = 1'b0;  nxt_wa = '0;  nxt_wd = '0;
      prv_we    = 1'b0;  prv_wa = '0;  prv_wd = '0;
      head_we   = 1'b0;  head_in = '0;
      tail_we   = 1'b0;  tail_in = '0;
      clr_lists = 1'b0;
      want_in     = want_ff;
      idx_in      = idx_ff;
      fl_in       = fl_ff;
      o_in        = o_ff;
      p_in        = p_ff;
      b_in        = b_ff;
      bok_in      = bok_ff;
      h_in        = h_ff;
      t_in        = t_ff;
      i_in        = i_ff;
      nhead_in    = nhead_ff;
      mark_addr_in = mark_addr_ff;
      mark_end_in  = mark_end_ff;
      mark_val_in  = mark_val_ff;
      res_in       = res_ff;

      unique case (dp_op) inside
         DP_NOP, DP_LOAD_OUT: begin
         end
         DP_LATCH: begin
            want_in = req_data.order;
            idx_in  = req_data.page_index;
            res_in  = '{status: RS_OK, block_page: '0, block_order: '0};
         end
         DP_INIT_START: begin
            clr_lists = 1'b1;
            i_in      = '0;
            nhead_in  = '0;
         end
         DP_INIT_PAGE: begin
            if (!init_end) begin
               ord_we = 1'b1;  ord_wa = i_ff[PAGE_W-1:0];  ord_wd = init_ord;
               alc_we = 1'b1;  alc_wa = i_ff[PAGE_W-1:0];  alc_wd = seg_used;
               mgd_we = 1'b1;  mgd_wa = i_ff[PAGE_W-1:0];  mgd_wd = is_head;
               if (is_head) begin
                  // append at the tail of its order's list
                  nxt_we = 1'b1;  nxt_wa = i_ff[PAGE_W-1:0];  nxt_wd = NIL;
                  prv_we = 1'b1;  prv_wa = i_ff[PAGE_W-1:0];  prv_wd = cur_tail;
                  if (cur_tail == NIL) begin
                     head_we = 1'b1;
                     head_in = i_ff;
                  end
                  tail_we  = 1'b1;
                  tail_in  = i_ff;
                  t_in     = cur_tail;
                  p_in     = i_ff[PAGE_W-1:0];
                  nhead_in = BIG_W'(i_ff) + (BIG_W'(1) << init_ord);
               end
               i_in = i_ff + 1'b1;
            end
         end
         DP_INIT_LINK: begin
            nxt_we = 1'b1;  nxt_wa = t_ff[PAGE_W-1:0];  nxt_wd = LINK_W'(p_ff);
         end
         DP_A_SEARCH: begin
            fl_in = srch_idx;
            if (!srch_found) begin
               res_in.status = RS_NOMEM;
            end
         end
         DP_SPLIT_RD, DP_FIN_RD: begin
            p_in    = cur_head[PAGE_W-1:0];
            rd_addr = cur_head[PAGE_W-1:0];
         end
         DP_SPLIT_UNL: begin
            head_we = 1'b1;
            head_in = nxt_rd_ff;
            if (nxt_rd_ff != NIL) begin
               prv_we = 1'b1;  prv_wa = nxt_rd_ff[PAGE_W-1:0];  prv_wd = NIL;
            end else begin
               tail_we = 1'b1;
               tail_in = NIL;
            end
            ord_we = 1'b1;  ord_wa = p_ff;  ord_wd = s_ord;
         end
         DP_SPLIT_PH1: begin
            // lower half goes in first, upper half in front of it
            bok_in = sp_sum < BIG_W'(MAX_PAGES);
            b_in   = sp_sum[PAGE_W-1:0];
            h_in   = cur_head;
            prv_we = 1'b1;  prv_wa = p_ff;
            prv_wd = (sp_sum < BIG_W'(MAX_PAGES)) ? LINK_W'(sp_sum) : NIL;
            nxt_we = 1'b1;  nxt_wa = p_ff;  nxt_wd = cur_head;
            head_we = 1'b1;
            head_in = LINK_W'(p_ff);
            if (cur_head == NIL) begin
               tail_we = 1'b1;
               tail_in = LINK_W'(p_ff);
            end
         end
         DP_SPLIT_PH2: begin
            if (h_ff != NIL) begin
               prv_we = 1'b1;  prv_wa = h_ff[PAGE_W-1:0];  prv_wd = LINK_W'(p_ff);
            end
            if (bok_ff) begin
               ord_we  = 1'b1;  ord_wa = b_ff;  ord_wd = s_ord;
               mgd_we  = 1'b1;  mgd_wa = b_ff;  mgd_wd = 1'b1;
               nxt_we  = 1'b1;  nxt_wa = b_ff;  nxt_wd = LINK_W'(p_ff);
               head_we = 1'b1;
               head_in = LINK_W'(b_ff);
            end
         end
         DP_SPLIT_PH3: begin
            if (bok_ff) begin
               prv_we = 1'b1;  prv_wa = b_ff;  prv_wd = NIL;
            end
            fl_in = s_ord;
         end
         DP_FIN_UNL: begin
            head_we = 1'b1;
            head_in = nxt_rd_ff;
            if (nxt_rd_ff != NIL) begin
               prv_we = 1'b1;  prv_wa = nxt_rd_ff[PAGE_W-1:0];  prv_wd = NIL;
            end else begin
               tail_we = 1'b1;
               tail_in = NIL;
            end
            mgd_we = 1'b1;  mgd_wa = p_ff;  mgd_wd = 1'b0;
            mark_addr_in = LINK_W'(p_ff);
            mark_end_in  = mk_end;
            mark_val_in  = 1'b1;
            res_in.block_page  = p_ff;
            res_in.block_order = fl_ff;
         end
         DP_F_RD: begin
            rd_addr = idx_ff;
            if (BIG_W'(idx_ff) >= n_big) begin
               res_in.status = RS_RANGE;
            end
         end
         DP_F_CHK: begin
            p_in = idx_ff;
            o_in = ord_rd_ff;
            if (fr_sum > n_big) begin
               res_in.status = RS_RANGE;
            end else if (!alc_rd_ff) begin
               res_in.status = RS_FREED;
            end
         end
         DP_M_CALC: begin
            rd_addr = bsum[PAGE_W-1:0];
            b_in    = bsum[PAGE_W-1:0];
         end
         DP_M_CHK: begin
            if (buddy_ok) begin
               // unlink the buddy and grow the block
               if (prv_rd_ff != NIL) begin
                  nxt_we = 1'b1;  nxt_wa = prv_rd_ff[PAGE_W-1:0];  nxt_wd = nxt_rd_ff;
               end else begin
                  head_we = 1'b1;
                  head_in = nxt_rd_ff;
               end
               if (nxt_rd_ff != NIL) begin
                  prv_we = 1'b1;  prv_wa = nxt_rd_ff[PAGE_W-1:0];  prv_wd = prv_rd_ff;
               end else begin
                  tail_we = 1'b1;
                  tail_in = prv_rd_ff;
               end
               mgd_we = 1'b1;  mgd_wa = b_ff;  mgd_wd = 1'b0;
               ord_we = 1'b1;  ord_wa = new_p;  ord_wd = o_ff + 1'b1;
               p_in   = new_p;
               o_in   = o_ff + 1'b1;
            end
         end
         DP_F_PH1: begin
            h_in   = cur_head;
            prv_we = 1'b1;  prv_wa = p_ff;  prv_wd = NIL;
            nxt_we = 1'b1;  nxt_wa = p_ff;  nxt_wd = cur_head;
            mgd_we = 1'b1;  mgd_wa = p_ff;  mgd_wd = 1'b1;
            head_we = 1'b1;
            head_in = LINK_W'(p_ff);
            if (cur_head == NIL) begin
               tail_we = 1'b1;
               tail_in = LINK_W'(p_ff);
            end
         end
         DP_F_PH2: begin
            if (h_ff != NIL) begin
               prv_we = 1'b1;  prv_wa = h_ff[PAGE_W-1:0];  prv_wd = LINK_W'(p_ff);
            end
            mark_addr_in = LINK_W'(p_ff);
            mark_end_in  = mk_end;
            mark_val_in  = 1'b0;
            res_in.block_page  = p_ff;
            res_in.block_order = o_ff;
         end
         DP_MARK: begin
            if (!mark_done) begin
               alc_we = 1'b1;  alc_wa = mark_addr_ff[PAGE_W-1:0];  alc_wd = mark_val_ff;
               mark_addr_in = mark_addr_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ord_we) ord_mem[ord_wa] <= ord_wd;
      ord_rd_ff <= ord_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mgd_we) mgd_mem[mgd_wa] <= mgd_wd;
      mgd_rd_ff <= mgd_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (alc_we) alc_mem[alc_wa] <= alc_wd;
      alc_rd_ff <= alc_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
      nxt_rd_ff <= nxt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (prv_we) prv_mem[prv_wa] <= prv_wd;
      prv_rd_ff <= prv_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clr_lists) begin
         for (int k = 0; k < NUM_ORDERS; k++) begin
            head_ff[k] <= NIL;
            tail_ff[k] <= NIL;
         end
      end else begin
         if (head_we) head_ff[lidx] <= head_in;
         if (tail_we) tail_ff[lidx] <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff      <= want_in;
      idx_ff       <= idx_in;
      fl_ff        <= fl_in;
      o_ff         <= o_in;
      p_ff         <= p_in;
      b_ff         <= b_in;
      bok_ff       <= bok_in;
      h_ff         <= h_in;
      t_ff         <= t_in;
      i_ff         <= i_in;
      nhead_ff     <= nhead_in;
      mark_addr_ff <= mark_addr_in;
      mark_end_ff  <= mark_end_in;
      mark_val_ff  <= mark_val_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid_in = (dp_op == DP_LOAD_OUT) ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = (dp_op == DP_LOAD_OUT) ? res_ff : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      dp_stat.found      = srch_found;
      dp_stat.more       = (dp_op == DP_A_SEARCH) ? (srch_idx > want_ff) : (s_ord > want_ff);
      dp_stat.init_end   = init_end;
      dp_stat.need_link  = is_head && (cur_tail != NIL);
      dp_stat.range_err  = BIG_W'(idx_ff) >= n_big;
      dp_stat.free_err   = (fr_sum > n_big) || !alc_rd_ff;
      dp_stat.merge_stop = merge_stop;
      dp_stat.buddy_ok   = buddy_ok;
      dp_stat.mark_done  = mark_done;
      dp_stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// ===== sv/buddy_page_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over one segment of up to 4096 pages with sixteen orders.
// ----------------------------------------------------------------------------
// Requests (init, allocate, free) arrive on req_valid/req_stall/req_data; one
// result per request leaves on rsp_valid/rsp_stall/rsp_data. The user must
// set the segment base, page count and used flag over the APB-style port only
// while idle; the block itself does not enforce this. One request is worked
// at a time; req_stall is low only when idle. Init walks the pages and links
// each carved block onto its order's list; allocate splits down to the order
// asked and then sweeps the allocated bits over the block; free merges with
// buddies and then sweeps the block. The sweep stops at page 4096. No memory,
// range errors, double frees and the unused code go straight to the result.
// The result is then loaded into the output register. The next request is
// taken while a finished result still waits there; a stalled result holds,
// and the following request waits only when it finishes too.
// Reset empties the free lists and restores the registers to base 0, 4096
// pages, not used. Page tables hold no reset value: issue init before use.
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [BASE_W-1:0] seg_base_ff;
   logic [CNT_W-1:0]  seg_count_ff;
   logic              seg_used_ff;
   logic              csr_wr;
   dp_op_type         dp_op;
   dp_stat_type       dp_stat;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_base_ff  <= BASE_RST;
         seg_count_ff <= COUNT_RST;
         seg_used_ff  <= USED_RST;
      end else if (csr_wr) begin
         case (paddr[3:2])
            REG_BASE:  seg_base_ff  <= pwdata[BASE_W-1:0];
            REG_COUNT: seg_count_ff <= pwdata[CNT_W-1:0];
            REG_USED:  seg_used_ff  <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_BASE:  prdata = CSR_DATA_W'(seg_base_ff);
         REG_COUNT: prdata = CSR_DATA_W'(seg_count_ff);
         REG_USED:  prdata = CSR_DATA_W'(seg_used_ff);
         default:   prdata = '0;
      endcase
   end

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .dp_stat   (dp_stat),
      .dp_op     (dp_op),
      .req_stall (req_stall)
   );

   bpa_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .dp_op     (dp_op),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .seg_base  (seg_base_ff),
      .seg_count (seg_count_ff),
      .seg_used  (seg_used_ff),
      .dp_stat   (dp_stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // an accepted request always leaves idle in the cycle after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted without leaving idle");

   // a new result only appears while a request is in progress
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised with no request in progress");

   // loading the output register always presents a result
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (dp_op == DP_LOAD_OUT) |=> rsp_valid)
      else $error("output load did not raise rsp_valid");

endmodule
